### src/i64dec_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i64dec_pkg
// shared widths, character codes and controller/datapath interface types
// ----------------------------------------------------------------------------
package i64dec_pkg;

   localparam int unsigned VALUE_W       = 64;
   localparam int unsigned CAP_W         = 8;
   localparam int unsigned CHAR_W        = 8;
   localparam int unsigned NUM_DIGITS    = 20;
   localparam int unsigned DIGIT_W       = 4;
   localparam int unsigned BCD_W         = NUM_DIGITS * DIGIT_W;
   localparam int unsigned DIGIT_IDX_W   = 5;
   localparam int unsigned NEED_W        = 5;
   localparam int unsigned BITS_PER_STEP = 4;
   localparam int unsigned CONV_STEPS    = VALUE_W / BITS_PER_STEP;
   localparam int unsigned STEP_CNT_W    = 4;

   localparam logic [CHAR_W-1:0]  CHAR_MINUS = 8'h2D;
   localparam logic [CHAR_W-1:0]  CHAR_NUL   = 8'h00;
   localparam logic [DIGIT_W-1:0] DIGIT_ZONE = 4'h3;

   typedef logic [1:0] emit_kind_type;
   localparam emit_kind_type EMIT_ERROR = 2'd0;
   localparam emit_kind_type EMIT_MINUS = 2'd1;
   localparam emit_kind_type EMIT_DIGIT = 2'd2;
   localparam emit_kind_type EMIT_NUL   = 2'd3;

   typedef struct packed {
      logic          load;
      logic          step;
      logic          size;
      logic          emit;
      emit_kind_type kind;
   } dp_cmd_type;

   typedef struct packed {
      logic conv_last;
      logic fits;
      logic negative;
      logic idx_zero;
      logic out_free;
   } dp_sts_type;

endpackage

### src/i64dec_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i64dec_dp
// datapath: magnitude, double-dabble bcd conversion, length check, output beat
// ----------------------------------------------------------------------------
module i64dec_dp (
   input  logic                                   clock,
   input  logic                                   reset,
   input  i64dec_pkg::dp_cmd_type                 cmd,
   output i64dec_pkg::dp_sts_type                 sts,
   input  logic [i64dec_pkg::VALUE_W-1:0]         req_value,
   input  logic                                   req_is_signed,
   input  logic [i64dec_pkg::CAP_W-1:0]           req_capacity,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic [i64dec_pkg::CHAR_W-1:0]          rsp_char_code,
   output logic                                   rsp_last,
   output logic                                   rsp_no_room
);
   import i64dec_pkg::*;

   logic [VALUE_W-1:0]     bin_ff, bin_in;
   logic [BCD_W-1:0]       bcd_ff, bcd_in;
   logic [STEP_CNT_W-1:0]  cnt_ff, cnt_in;
   logic                   neg_ff, neg_in;
   logic [CAP_W-1:0]       cap_ff, cap_in;
   logic [DIGIT_IDX_W-1:0] idx_ff, idx_in;
   logic                   fits_ff, fits_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [CHAR_W-1:0]      rsp_char_ff, rsp_char_in;
   logic                   rsp_last_ff, rsp_last_in;
   logic                   rsp_no_room_ff, rsp_no_room_in;

   logic [VALUE_W-1:0]     bin_step;
   logic [BCD_W-1:0]       bcd_step;
   logic [DIGIT_IDX_W-1:0] ndig;
   logic [NEED_W-1:0]      need;
   logic [DIGIT_W-1:0]     digit_sel;
   logic                   load_neg;

   // four shift/add-3 passes per cycle
   always_comb begin
      bin_step = bin_ff;
      bcd_step = bcd_ff;
      for (int s = 0; s < BITS_PER_STEP; s++) begin
         for (int d = 0; d < NUM_DIGITS; d++) begin
            if (bcd_step[d*DIGIT_W +: DIGIT_W] >= DIGIT_W'(5)) begin
               bcd_step[d*DIGIT_W +: DIGIT_W] = bcd_step[d*DIGIT_W +: DIGIT_W] + DIGIT_W'(3);
            end
         end
         {bcd_step, bin_step} = {bcd_step[BCD_W-2:0], bin_step, 1'b0};
      end
   end

   // digit count: position of the highest nonzero digit, at least one
   always_comb begin
      ndig = DIGIT_IDX_W'(1);
      for (int d = 0; d < NUM_DIGITS; d++) begin
         if (bcd_ff[d*DIGIT_W +: DIGIT_W] != '0) begin
            ndig = DIGIT_IDX_W'(d + 1);
         end
      end
   end

   assign need      = NEED_W'(ndig) + NEED_W'(1) + NEED_W'(neg_ff);
   assign digit_sel = bcd_ff[{idx_ff, 2'b00} +: DIGIT_W];
   assign load_neg  = req_is_signed & req_value[VALUE_W-1];

   always_comb begin
      bin_in         = bin_ff;
      bcd_in         = bcd_ff;
      cnt_in         = cnt_ff;
      neg_in         = neg_ff;
      cap_in         = cap_ff;
      idx_in         = idx_ff;
      fits_in        = fits_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_char_in    = rsp_char_ff;
      rsp_last_in    = rsp_last_ff;
      rsp_no_room_in = rsp_no_room_ff;

      if (cmd.load) begin
         bin_in = load_neg ? (~req_value + VALUE_W'(1)) : req_value;
         bcd_in = '0;
         cnt_in = '0;
         neg_in = load_neg;
         cap_in = req_capacity;
      end
      if (cmd.step) begin
         bin_in = bin_step;
         bcd_in = bcd_step;
         cnt_in = cnt_ff + STEP_CNT_W'(1);
      end
      if (cmd.size) begin
         idx_in  = ndig - DIGIT_IDX_W'(1);
         fits_in = CAP_W'(need) <= cap_ff;
      end

      if (cmd.emit) begin
         rsp_valid_in   = 1'b1;
         rsp_last_in    = 1'b0;
         rsp_no_room_in = 1'b0;
         unique case (cmd.kind)
            EMIT_ERROR: begin
               rsp_char_in    = CHAR_NUL;
               rsp_last_in    = 1'b1;
               rsp_no_room_in = 1'b1;
            end
            EMIT_MINUS: begin
               rsp_char_in = CHAR_MINUS;
            end
            EMIT_DIGIT: begin
               rsp_char_in = {DIGIT_ZONE, digit_sel};
               idx_in      = idx_ff - DIGIT_IDX_W'(1);
            end
            EMIT_NUL: begin
               rsp_char_in = CHAR_NUL;
               rsp_last_in = 1'b1;
            end
            default: begin
               rsp_char_in = CHAR_NUL;
            end
         endcase
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      bin_ff         <= bin_in;
      bcd_ff         <= bcd_in;
      cnt_ff         <= cnt_in;
      neg_ff         <= neg_in;
      cap_ff         <= cap_in;
      idx_ff         <= idx_in;
      fits_ff        <= fits_in;
      rsp_char_ff    <= rsp_char_in;
      rsp_last_ff    <= rsp_last_in;
      rsp_no_room_ff <= rsp_no_room_in;
   end

   assign sts.conv_last = (cnt_ff == STEP_CNT_W'(CONV_STEPS - 1));
   assign sts.fits      = fits_ff;
   assign sts.negative  = neg_ff;
   assign sts.idx_zero  = (idx_ff == '0);
   assign sts.out_free  = ~rsp_valid_ff | rsp_ready;

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_char_code = rsp_char_ff;
   assign rsp_last      = rsp_last_ff;
   assign rsp_no_room   = rsp_no_room_ff;

`ifndef SYNTH
   // a converted digit is always a decimal digit
   a_digit_decimal: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit && cmd.kind == EMIT_DIGIT) |-> (digit_sel <= DIGIT_W'(9)))
      else $error("bcd digit out of range");
`endif

endmodule

### src/i64dec_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i64dec_ctrl
// sequencer: load, convert, size check, then, unless the receiver stalls, one character beat per cycle
// ----------------------------------------------------------------------------
module i64dec_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   output i64dec_pkg::dp_cmd_type cmd,
   input  i64dec_pkg::dp_sts_type sts
);
   import i64dec_pkg::*;

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_CONV   = 3'd1;
   localparam logic [2:0] ST_CHECK  = 3'd2;
   localparam logic [2:0] ST_DECIDE = 3'd3;
   localparam logic [2:0] ST_DIGITS = 3'd4;
   localparam logic [2:0] ST_TERM   = 3'd5;

   logic [2:0] state_ff, state_in;

   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      cmd.kind = EMIT_NUL;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_CONV;
            end
         end
         ST_CONV: begin
            cmd.step = 1'b1;
            if (sts.conv_last) begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            cmd.size = 1'b1;
            state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            priority if (!sts.fits) begin
               if (sts.out_free) begin
                  cmd.emit = 1'b1;
                  cmd.kind = EMIT_ERROR;
                  state_in = ST_IDLE;
               end
            end else if (sts.negative) begin
               if (sts.out_free) begin
                  cmd.emit = 1'b1;
                  cmd.kind = EMIT_MINUS;
                  state_in = ST_DIGITS;
               end
            end else begin
               state_in = ST_DIGITS;
            end
         end
         ST_DIGITS: begin
            if (sts.out_free) begin
               cmd.emit = 1'b1;
               cmd.kind = EMIT_DIGIT;
               if (sts.idx_zero) begin
                  state_in = ST_TERM;
               end
            end
         end
         ST_TERM: begin
            if (sts.out_free) begin
               cmd.emit = 1'b1;
               cmd.kind = EMIT_NUL;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

`ifndef SYNTH
   // never overwrite a beat the receiver has not taken
   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> sts.out_free)
      else $error("beat issued into a full output register");

   // conversion runs its full step count
   a_conv_hold: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CONV && !sts.conv_last) |=> (state_ff == ST_CONV))
      else $error("conversion left early");

   // a closing beat ends the item
   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit && (cmd.kind == EMIT_NUL || cmd.kind == EMIT_ERROR)) |=>
         (state_ff == ST_IDLE))
      else $error("closing beat did not return to idle");
`endif

endmodule

### src/int64_to_decimal_ascii_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// int64_to_decimal_ascii_top
// 64-bit signed/unsigned integer to decimal ascii text, one character a beat
// ----------------------------------------------------------------------------
// usage:
//   req channel (valid/ready) takes value, is_signed and capacity. the block
//   holds one item at a time; req_ready is high only while it is idle.
//   rsp channel (valid/ready) returns the text one character per beat:
//   optional '-', digits most significant first, then a nul beat with last
//   set. if sign + digits + nul exceed capacity, a single nul beat with last
//   and no_room set is sent instead.
//   timing: conversion is a double-dabble loop at four bits per cycle,
//   followed by the length check state and the decide state, which sends
//   the '-' or the no_room beat; the digits and the nul beat follow. an
//   item produces 1 to 21 beats.
//   the output register decouples the sides: a beat waits there while the
//   receiver stalls, and the sequencer just holds until it is taken.
//   reset (synchronous, active high) returns to idle and drops rsp_valid;
//   no state is kept between items.
// ----------------------------------------------------------------------------
module int64_to_decimal_ascii_top (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [i64dec_pkg::VALUE_W-1:0] req_value,
   input  logic                          req_is_signed,
   input  logic [i64dec_pkg::CAP_W-1:0]   req_capacity,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [i64dec_pkg::CHAR_W-1:0]  rsp_char_code,
   output logic                          rsp_last,
   output logic                          rsp_no_room
);
   import i64dec_pkg::*;

   // command and status between sequencer and datapath
   dp_cmd_type cmd;
   dp_sts_type sts;

   // sequencer: owns req_ready and decides each output beat
   i64dec_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .cmd       (cmd),
      .sts       (sts)
   );

   // datapath: magnitude, bcd conversion, length check, output register
   i64dec_dp u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .sts           (sts),
      .req_value     (req_value),
      .req_is_signed (req_is_signed),
      .req_capacity  (req_capacity),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_char_code (rsp_char_code),
      .rsp_last      (rsp_last),
      .rsp_no_room   (rsp_no_room)
   );

endmodule
